// ===== src/onbfm_pkg.sv =====
// Shared constants and types for the optimal normal basis field multiplier.
// Used by onbfm_terms and onb_field_multiply; depends on nothing else.
`default_nettype none

package onbfm_pkg;

   localparam int MAX_DEGREE  = 63;
   localparam int TABLE_DEPTH = 125;

   localparam int DEG_W = 6;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int VAL_W = DEG_W;
   // Extended operand register: one position for every offset a table entry can hold.
   localparam int EXT_W = 2 ** DEG_W;

   localparam logic [DEG_W-1:0] RESET_DEGREE = DEG_W'(MAX_DEGREE);

   localparam logic FUNC_WRITE    = 1'b0;
   localparam logic FUNC_MULTIPLY = 1'b1;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] value;
   } tbl_wr_type;

endpackage

`default_nettype wire

// ===== src/onbfm_terms.sv =====
// Multiplication table store and one registered AND term per table entry.
// Depends on onbfm_pkg.
`default_nettype none

module onbfm_terms
   import onbfm_pkg::*;
(
   input  wire logic                   clock,
   input  wire tbl_wr_type             tbl_wr,
   input  wire logic                   step_en,
   input  wire logic [DEG_W-1:0]       degree,
   input  wire logic [MAX_DEGREE-1:0]  a_bits,
   input  wire logic [EXT_W-1:0]       b_ext,
   output logic      [TABLE_DEPTH-1:0] term_bits
);

   logic [VAL_W-1:0]       mult_table_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] terms_ff;
   logic [TABLE_DEPTH-1:0] terms_in;

   // Entry i pairs coefficient (i+1)/2 of the rotated first factor with the
   // coefficient of the rotated second factor named by the entry. Entries
   // whose first-factor position reaches the degree lie beyond 2m-1 terms.
   for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_term
      localparam int HPOS = (gi + 1) / 2;
      assign terms_in[gi] = (DEG_W'(HPOS) < degree) && a_bits[HPOS]
                            && b_ext[mult_table_ff[gi]];
   end

   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         mult_table_ff[tbl_wr.idx] <= tbl_wr.value;
      end
      if (step_en) begin
         terms_ff <= terms_in;
      end
   end

   assign term_bits = terms_ff;

endmodule

`default_nettype wire

// ===== src/onb_field_multiply.sv =====
// A multiply runs the fill pass, the bit loop over the m product bits, the parity step
// and the done state, which loads the product once the result register is free.
// Requests are taken only while idle, so a new multiply or table write waits until the
// single bit-serial product loop has finished; a table write is done on acceptance. With
// degree zero the multiply goes straight to the done state. Reset is synchronous: control
// clears, the degree returns to 63, and the table holds no defined contents until its
// entries are written (there is no clearing pass).
`default_nettype none

module onb_field_multiply
   import onbfm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Item input channel.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_func,
   input  wire logic [IDX_W-1:0]      req_table_index,
   input  wire logic [VAL_W-1:0]      req_table_value,
   input  wire logic [MAX_DEGREE-1:0] req_operand_a,
   input  wire logic [MAX_DEGREE-1:0] req_operand_b,
   // Result channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [MAX_DEGREE-1:0] rsp_product,
   // Degree register write channel.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [DEG_W-1:0]      csr_field_degree
);

   // The product is built one bit per cycle in the classic Massey-Omura way.
   // The first factor sits in a circular shift register of m bits. The second
   // factor sits in a 64-bit extended register whose position p always holds
   // coefficient (p + k) mod m, so a table offset of any value selects the right
   // coefficient without a modulo. Before the bit loop, a fill pass copies
   // position p - m into position p for p = m .. 63, one position per cycle.
   // After that, a rotation by one keeps the extended form: the new top
   // position takes position 64 - m.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_MUL,
      ST_LAST,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [DEG_W-1:0]          degree_ff;
   logic [DEG_W-1:0]          cnt_ff;
   logic [DEG_W-1:0]          kq_ff;
   logic                      tv_ff;
   logic                      rsp_valid_ff;
   logic [MAX_DEGREE-1:0]     rsp_product_ff;

   logic [MAX_DEGREE-1:0]     a_ff, a_in;
   logic [EXT_W-1:0]          b_ext_ff, b_ext_in;
   logic [MAX_DEGREE-1:0]     prod_ff, prod_in;

   logic                      req_accept;
   logic                      rsp_take;
   logic                      rsp_load;
   logic                      mul_start;
   logic [DEG_W-1:0]          deg_last;
   logic [DEG_W-1:0]          deg_neg;
   logic [DEG_W-1:0]          fill_src;
   logic [TABLE_DEPTH-1:0]    term_bits;
   tbl_wr_type                tbl_wr;

   assign req_stall  = (state_ff != ST_IDLE);
   // The degree only changes while idle and with no request offered, so a multiply
   // never starts in the same cycle as a degree write.
   assign csr_ready  = (state_ff == ST_IDLE) && !req_valid;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_take);
   assign mul_start  = req_accept && (req_func == FUNC_MULTIPLY);

   // Writes past the end of the table are dropped.
   assign tbl_wr.en    = req_accept && (req_func == FUNC_WRITE)
                         && (req_table_index < IDX_W'(TABLE_DEPTH));
   assign tbl_wr.idx   = req_table_index;
   assign tbl_wr.value = req_table_value;

   assign deg_last = degree_ff - DEG_W'(1);
   assign deg_neg  = DEG_W'(0) - degree_ff;
   assign fill_src = cnt_ff - degree_ff;

   onbfm_terms u_terms (
      .clock     (clock),
      .tbl_wr    (tbl_wr),
      .step_en   (state_ff == ST_MUL),
      .degree    (degree_ff),
      .a_bits    (a_ff),
      .b_ext     (b_ext_ff),
      .term_bits (term_bits)
   );

   // Operand and product registers.
   always_comb begin
      a_in     = a_ff;
      b_ext_in = b_ext_ff;
      prod_in  = prod_ff;
      if (mul_start) begin
         a_in     = req_operand_a;
         b_ext_in = {1'b0, req_operand_b};
         prod_in  = '0;
      end else begin
         unique case (state_ff)
            ST_FILL: begin
               b_ext_in[cnt_ff] = b_ext_ff[fill_src];
            end
            ST_MUL: begin
               a_in           = {a_ff[0], a_ff[MAX_DEGREE-1:1]};
               a_in[deg_last] = a_ff[0];
               b_ext_in       = {b_ext_ff[deg_neg], b_ext_ff[EXT_W-1:1]};
            end
            default: begin
            end
         endcase
      end
      // The terms registered for bit kq reduce to that product bit in the following cycle.
      if (tv_ff) begin
         prod_in[kq_ff] = ^term_bits;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ext_ff <= b_ext_in;
      prod_ff  <= prod_in;
   end

   // Sequencer, degree register and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         degree_ff      <= RESET_DEGREE;
         cnt_ff         <= '0;
         kq_ff          <= '0;
         tv_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_product_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            degree_ff <= csr_field_degree;
         end
         if (rsp_load) begin
            rsp_valid_ff   <= 1'b1;
            rsp_product_ff <= prod_ff;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               tv_ff <= 1'b0;
               if (mul_start) begin
                  cnt_ff <= degree_ff;
                  if (degree_ff == '0) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_FILL;
                  end
               end
            end
            ST_FILL: begin
               if (cnt_ff == DEG_W'(EXT_W - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_MUL;
               end else begin
                  cnt_ff <= cnt_ff + DEG_W'(1);
               end
            end
            ST_MUL: begin
               tv_ff <= 1'b1;
               kq_ff <= cnt_ff;
               if (cnt_ff == deg_last) begin
                  state_ff <= ST_LAST;
               end else begin
                  cnt_ff <= cnt_ff + DEG_W'(1);
               end
            end
            ST_LAST: begin
               tv_ff    <= 1'b0;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // The result register frees up in the same cycle its transfer completes.
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_product = rsp_product_ff;

`ifndef ASSERT_OFF
   // A parity step only follows a bit cycle.
   a_tv_after_mul: assert property (@(posedge clock) disable iff (reset)
      tv_ff |-> ($past(state_ff) == ST_MUL))
      else $error("product bit reduced without a preceding bit cycle");

   // The fill pointer never drops below the degree, so the copy source stays in range.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (cnt_ff >= degree_ff))
      else $error("fill pointer below field degree");

   // The bit counter stays below the degree throughout the bit loop.
   a_mul_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff < degree_ff))
      else $error("bit counter reached field degree");

   // A finished product has no bits at or above the degree.
   a_prod_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ((prod_ff >> degree_ff) == '0))
      else $error("product bit set at or above field degree");
`endif

endmodule

`default_nettype wire
